// ===== hdl/postfix_expression_evaluator_defines.svh =====
// assertion macros shared by the postfix evaluator rtl
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define PEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same check, also active during reset
`define PEE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/pee_pkg.sv =====
// shared constants and types of the postfix evaluator
`timescale 1ns / 1ps
package pee_pkg;

  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [SYM_W-1:0] SYM_END  = 8'h3B;  // ';'
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;  // '0'
  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;  // '*'
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;  // '/'

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_LEFTOVER  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV,
    FSM_DIVFIN
  } fsm_e;

endpackage

// ===== hdl/postfix_expression_evaluator.sv =====
// top level of the postfix (rpn) expression evaluator
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_defines.svh"

// Postfix evaluator, one ASCII character per input word. Digits and any other
// non-operator character push (code - '0'); + - * / pop two values and push the
// 32-bit wrapping result (division truncates toward zero); ';' ends the
// expression and emits one output word (value, status). The top of stack lives
// in a register and the entries below it in a 64 x 32 synchronous RAM with a
// registered read port. A push or ';' is done in FSM_IDLE alone; + - * read the
// left operand from the RAM, then apply the ALU / 32x32 multiplier in FSM_EXEC;
// / goes on through the restoring divider that retires one quotient bit per
// cycle (FSM_DIV), then FSM_DIVFIN. After an error word (underflow, overflow,
// divide by zero) input is dropped up to and including the next ';', which
// clears the stack silently. While a finished word waits in the output
// register and the receiver is not ready, no input word is taken.
module postfix_expression_evaluator
  import pee_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SYM_W-1:0]    symbol_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [STATUS_W-1:0] status_o
);

  // control state
  fsm_e                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 discard_q, discard_d;
  logic                 out_valid_q, out_valid_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // payload state
  logic [DATA_W-1:0]    tos_q, tos_d;        // top of stack
  logic [SYM_W-1:0]     op_q, op_d;
  logic [DATA_W-1:0]    value_q, value_d;
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    dvs_q, dvs_d;        // divisor magnitude
  logic [DATA_W-1:0]    quo_q, quo_d;        // dividend shifting into quotient
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic                 neg_q, neg_d;

  // stack memory: entries below the top of stack
  logic [DATA_W-1:0]    mem_q [STACK_DEPTH];
  logic [DATA_W-1:0]    rd_data_q;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;

  logic                 accept;
  logic                 is_op;
  logic [CNT_W-1:0]     push_idx;
  logic [CNT_W-1:0]     lhs_idx;
  logic [DATA_W:0]      div_sh;
  logic                 div_ge;
  logic [DATA_W:0]      div_diff;
  logic [2*DATA_W-1:0]  mul_full;

  assign in_ready_o  = (state_q == FSM_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  assign is_op = (symbol_i == SYM_ADD) || (symbol_i == SYM_SUB) ||
                 (symbol_i == SYM_MUL) || (symbol_i == SYM_DIV);

  // old top goes to entry count-1 on a push, left operand sits at count-2
  assign push_idx = count_q - CNT_W'(1);
  assign lhs_idx  = count_q - CNT_W'(2);
  assign wr_addr  = push_idx[ADDR_W-1:0];
  assign rd_addr  = lhs_idx[ADDR_W-1:0];

  // one restoring divide step
  assign div_sh   = {rem_q, quo_q[DATA_W-1]};
  assign div_ge   = div_sh >= {1'b0, dvs_q};
  assign div_diff = div_sh - {1'b0, dvs_q};

  assign mul_full = rd_data_q * tos_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    discard_d   = discard_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_cnt_d   = div_cnt_q;
    tos_d       = tos_q;
    op_d        = op_q;
    value_d     = value_q;
    status_d    = status_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (discard_q) begin
            // error recovery: drop everything up to the end marker
            if (symbol_i == SYM_END) begin
              discard_d = 1'b0;
              count_d   = '0;
            end
          end else if (symbol_i == SYM_END) begin
            count_d     = '0;
            out_valid_d = 1'b1;
            if (count_q == CNT_W'(1)) begin
              value_d  = tos_q;
              status_d = ST_OK;
            end else if (count_q == '0) begin
              value_d  = '0;
              status_d = ST_OK;
            end else begin
              value_d  = '0;
              status_d = ST_LEFTOVER;
            end
          end else if (is_op) begin
            if (count_q < CNT_W'(2)) begin
              out_valid_d = 1'b1;
              value_d     = '0;
              status_d    = ST_UNDERFLOW;
              discard_d   = 1'b1;
            end else begin
              // fetch the left operand, right operand is the top register
              rd_en   = 1'b1;
              op_d    = symbol_i;
              state_d = FSM_EXEC;
            end
          end else if (count_q >= CNT_W'(STACK_DEPTH)) begin
            out_valid_d = 1'b1;
            value_d     = '0;
            status_d    = ST_OVERFLOW;
            discard_d   = 1'b1;
          end else begin
            // push: spill the old top into memory
            wr_en   = (count_q != '0);
            tos_d   = DATA_W'(symbol_i) - DATA_W'(SYM_ZERO);
            count_d = count_q + CNT_W'(1);
          end
        end
      end

      FSM_EXEC: begin
        state_d = FSM_IDLE;
        case (op_q)
          SYM_ADD: begin
            tos_d   = rd_data_q + tos_q;
            count_d = count_q - CNT_W'(1);
          end
          SYM_SUB: begin
            tos_d   = rd_data_q - tos_q;
            count_d = count_q - CNT_W'(1);
          end
          SYM_MUL: begin
            tos_d   = mul_full[DATA_W-1:0];
            count_d = count_q - CNT_W'(1);
          end
          default: begin
            // divide
            if (tos_q == '0) begin
              out_valid_d = 1'b1;
              value_d     = '0;
              status_d    = ST_DIVZERO;
              discard_d   = 1'b1;
            end else begin
              quo_d     = rd_data_q[DATA_W-1] ? ('0 - rd_data_q) : rd_data_q;
              dvs_d     = tos_q[DATA_W-1] ? ('0 - tos_q) : tos_q;
              neg_d     = rd_data_q[DATA_W-1] ^ tos_q[DATA_W-1];
              rem_d     = '0;
              div_cnt_d = '1;
              state_d   = FSM_DIV;
            end
          end
        endcase
      end

      FSM_DIV: begin
        rem_d     = div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
        quo_d     = {quo_q[DATA_W-2:0], div_ge};
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        if (div_cnt_q == '0) begin
          state_d = FSM_DIVFIN;
        end
      end

      FSM_DIVFIN: begin
        tos_d   = neg_q ? ('0 - quo_q) : quo_q;
        count_d = count_q - CNT_W'(1);
        state_d = FSM_IDLE;
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      discard_q   <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q    <= tos_d;
    op_q     <= op_d;
    value_q  <= value_d;
    status_q <= status_d;
    dvs_q    <= dvs_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
  end

  // stack ram, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= tos_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // checks
  `PEE_ASSERT(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `PEE_ASSERT(a_exec_has_operands, state_q == FSM_EXEC |-> count_q >= CNT_W'(2),
    "operator executing with fewer than two values")
  `PEE_ASSERT(a_error_value_zero, out_valid_q && status_q != ST_OK |-> value_q == '0,
    "error word with nonzero value")
  `PEE_ASSERT(a_discard_only_idle, discard_q |-> state_q == FSM_IDLE,
    "discarding while an operator is in flight")
  `PEE_ASSERT(a_div_enters_fin, state_q == FSM_DIV && div_cnt_q == '0 |=> state_q == FSM_DIVFIN,
    "divider did not finish after its last step")

endmodule
